// ===== hdl/mlrs_pkg.sv =====
package mlrs_pkg;

  localparam int LINES          = 144;
  localparam int BYTES_PER_LINE = 9;
  localparam int MODE_BITS      = 6;
  localparam int ADDR_BITS      = 10;
  localparam int DUMMY_BITS     = 6;
  localparam int TRAILER_CLOCKS = 16;

  localparam int PIX_BITS = 8 * BYTES_PER_LINE;
  localparam int LINE_W   = 8;
  localparam int BIDX_W   = 4;
  localparam int CNT_W    = 7;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [LINE_W-1:0] line;
    logic [BIDX_W-1:0] byte_index;
    logic [7:0]        value;
    logic [5:0]        mode;
    logic [LINE_W-1:0] start_line;
    logic [LINE_W-1:0] end_line;
  } in_item_t;

  typedef struct packed {
    logic chip_select;
    logic clock_pulse;
    logic data_bit;
    logic busy_res;
    logic frame_done;
  } out_item_t;

  // one port of the frame store: a write or a read per cycle
  typedef struct packed {
    logic                we;
    logic                re;
    logic [LINE_W-1:0]   addr;
    logic [PIX_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic              wr_go;
    logic              fill_go;
    logic [LINE_W-1:0] line;
    logic [BIDX_W-1:0] bidx;
    logic [7:0]        value;
  } upd_cmd_t;

  typedef struct packed {
    logic              tick_go;
    logic              start_go;
    logic [5:0]        mode;
    logic [LINE_W-1:0] start_line;
    logic [LINE_W-1:0] end_line;
  } ser_cmd_t;

endpackage

// ===== hdl/memory_lcd_refresh_serializer.sv =====
// Memory LCD refresh serializer: one-bit frame store (144 lines x 9 bytes)
// and a serial frame generator for the panel link.
// Commands enter on in_data and are taken at a clock edge with start high
// and busy low. Every taken beat yields one result beat on out_data, marked
// by out_strobe in the cycle right after the beat was taken.
// The receiver cannot stall; out_strobe lasts exactly one cycle.
// Tick beats can be issued every cycle while busy is low: each one moves
// one serial clock (mode bits, then per line address, pixels, dummy bits,
// then trailer). The line word for a line is read from the store when its
// address phase begins, so a tick never waits on the memory.
// A byte write is a read-modify-write of the line word: busy stays high
// while the merged word is written back. A fill sweeps the store one line
// per cycle; busy stays high until the last line is written. Writes, fills
// and starts offered while a refresh runs are ignored, but still answered.
// Reset (rst_n low, synchronous) idles the serializer and the update
// sequencer; the store contents stay undefined until written.
module memory_lcd_refresh_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mlrs_pkg::in_item_t   in_data,
  output logic                 out_strobe,
  output mlrs_pkg::out_item_t  out_data
);
  import mlrs_pkg::*;

  logic      accept;
  logic      running;
  logic      upd_busy;
  logic      is_tick;
  upd_cmd_t  upd_cmd;
  ser_cmd_t  ser_cmd;
  mem_req_t  upd_req, ser_req, mem_req;
  out_item_t ser_res, res;
  logic [PIX_BITS-1:0] rdata;
  logic      out_strobe_r;
  out_item_t out_data_r;

  assign accept  = start && !upd_busy;
  assign is_tick = (in_data.opcode == OP_TICK);

  always_comb begin
    upd_cmd         = '0;
    upd_cmd.wr_go   = accept && !running && (in_data.opcode == OP_WRITE) &&
                      (in_data.line < LINE_W'(LINES)) &&
                      (in_data.byte_index < BIDX_W'(BYTES_PER_LINE));
    upd_cmd.fill_go = accept && !running && (in_data.opcode == OP_FILL);
    upd_cmd.line    = in_data.line;
    upd_cmd.bidx    = in_data.byte_index;
    upd_cmd.value   = in_data.value;

    ser_cmd            = '0;
    ser_cmd.tick_go    = accept && is_tick;
    ser_cmd.start_go   = accept && !running && (in_data.opcode == OP_START);
    ser_cmd.mode       = in_data.mode;
    ser_cmd.start_line = in_data.start_line;
    ser_cmd.end_line   = in_data.end_line;
  end

  // update and refresh never use the port in the same cycle
  assign mem_req = (upd_req.we || upd_req.re) ? upd_req : ser_req;

  mlrs_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  mlrs_upd u_upd (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (upd_cmd),
    .rdata (rdata),
    .req   (upd_req),
    .busy  (upd_busy)
  );

  mlrs_ser u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ser_cmd),
    .rdata   (rdata),
    .req     (ser_req),
    .res     (ser_res),
    .running (running)
  );

  always_comb begin
    if (is_tick) begin
      res = ser_res;
    end else begin
      res             = '0;
      res.chip_select = running || ser_cmd.start_go;
      res.busy_res    = running || ser_cmd.start_go;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
    end
    out_data_r <= res;
  end

  assign busy       = upd_busy;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== hdl/mlrs_store.sv =====
module mlrs_store (
  input  logic                          clk,
  input  mlrs_pkg::mem_req_t            req,
  output logic [mlrs_pkg::PIX_BITS-1:0] rdata
);
  import mlrs_pkg::*;

  logic [PIX_BITS-1:0] mem [LINES];
  logic [PIX_BITS-1:0] rdata_r;

  // read data holds between reads; the serializer shifts straight out of it
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mlrs_upd.sv =====
module mlrs_upd (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlrs_pkg::upd_cmd_t            cmd,
  input  logic [mlrs_pkg::PIX_BITS-1:0] rdata,
  output mlrs_pkg::mem_req_t            req,
  output logic                          busy
);
  import mlrs_pkg::*;

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_WB   = 3'b010,
    U_FILL = 3'b100
  } ustate_t;

  ustate_t           state_r, state_nxt;
  logic [LINE_W-1:0] addr_r, addr_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [7:0]        value_r, value_nxt;
  logic [PIX_BITS-1:0] merged;

  always_comb begin
    merged = rdata;
    for (int k = 0; k < BYTES_PER_LINE; k++) begin
      if (bidx_r == BIDX_W'(k)) begin
        merged[PIX_BITS-1-8*k -: 8] = value_r;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    bidx_nxt  = bidx_r;
    value_nxt = value_r;
    req       = '0;
    unique case (state_r)
      U_IDLE: begin
        if (cmd.wr_go) begin
          // fetch the line now, merge the byte and write back next cycle
          req.re    = 1'b1;
          req.addr  = cmd.line;
          addr_nxt  = cmd.line;
          bidx_nxt  = cmd.bidx;
          value_nxt = cmd.value;
          state_nxt = U_WB;
        end else if (cmd.fill_go) begin
          addr_nxt  = '0;
          value_nxt = cmd.value;
          state_nxt = U_FILL;
        end
      end
      U_WB: begin
        req.we    = 1'b1;
        req.addr  = addr_r;
        req.wdata = merged;
        state_nxt = U_IDLE;
      end
      U_FILL: begin
        req.we    = 1'b1;
        req.addr  = addr_r;
        req.wdata = {BYTES_PER_LINE{value_r}};
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == LINE_W'(LINES - 1)) begin
          state_nxt = U_IDLE;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    addr_r  <= addr_nxt;
    bidx_r  <= bidx_nxt;
    value_r <= value_nxt;
  end

  assign busy = (state_r != U_IDLE);

endmodule

// ===== hdl/mlrs_ser.sv =====
module mlrs_ser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlrs_pkg::ser_cmd_t            cmd,
  input  logic [mlrs_pkg::PIX_BITS-1:0] rdata,
  output mlrs_pkg::mem_req_t            req,
  output mlrs_pkg::out_item_t           res,
  output logic                          running
);
  import mlrs_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_MODE  = 6'b000010,
    PH_ADDR  = 6'b000100,
    PH_PIX   = 6'b001000,
    PH_DUMMY = 6'b010000,
    PH_TRAIL = 6'b100000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  bit_count_r, bit_count_nxt, bc_inc;
  logic [LINE_W-1:0] cur_line_r, cur_line_nxt;
  logic [LINE_W-1:0] last_line_r, last_line_nxt;
  logic [MODE_BITS-1:0] mode_word_r, mode_word_nxt;
  logic [MODE_BITS-1:0] mode_sh;
  logic [ADDR_BITS-1:0] addr_sh;
  logic [PIX_BITS-1:0]  pix_sh;
  logic next_line, go_trail;

  assign bc_inc  = bit_count_r + 1'b1;
  assign mode_sh = mode_word_r >> (CNT_W'(MODE_BITS - 1) - bit_count_r);
  assign addr_sh = ADDR_BITS'(cur_line_r) >> (CNT_W'(ADDR_BITS - 1) - bit_count_r);
  assign pix_sh  = rdata >> (CNT_W'(PIX_BITS - 1) - bit_count_r);

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    cur_line_nxt  = cur_line_r;
    last_line_nxt = last_line_r;
    mode_word_nxt = mode_word_r;
    req           = '0;
    res           = '0;
    next_line     = 1'b0;
    go_trail      = 1'b0;

    if (cmd.start_go) begin
      mode_word_nxt = cmd.mode;
      cur_line_nxt  = cmd.start_line;
      last_line_nxt = (cmd.end_line < LINE_W'(LINES)) ? cmd.end_line : LINE_W'(LINES - 1);
      phase_nxt     = PH_MODE;
      bit_count_nxt = '0;
    end else if (cmd.tick_go && phase_r != PH_IDLE) begin
      res.chip_select = 1'b1;
      res.clock_pulse = 1'b1;
      res.busy_res    = 1'b1;
      bit_count_nxt   = bc_inc;
      unique case (phase_r)
        PH_MODE: begin
          res.data_bit = mode_sh[0];
          if (bc_inc == CNT_W'(MODE_BITS)) begin
            bit_count_nxt = '0;
            if (cur_line_r > last_line_r) begin
              go_trail = 1'b1;
            end else begin
              // line word lands in the store's read register long before pixels
              req.re    = 1'b1;
              req.addr  = cur_line_r;
              phase_nxt = PH_ADDR;
            end
          end
        end
        PH_ADDR: begin
          res.data_bit = addr_sh[0];
          if (bc_inc == CNT_W'(ADDR_BITS)) begin
            bit_count_nxt = '0;
            phase_nxt     = PH_PIX;
          end
        end
        PH_PIX: begin
          res.data_bit = pix_sh[0];
          if (bc_inc == CNT_W'(PIX_BITS)) begin
            bit_count_nxt = '0;
            if (DUMMY_BITS == 0) begin
              next_line = 1'b1;
            end else begin
              phase_nxt = PH_DUMMY;
            end
          end
        end
        PH_DUMMY: begin
          if (bc_inc == CNT_W'(DUMMY_BITS)) begin
            next_line = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (bc_inc == CNT_W'(TRAILER_CLOCKS)) begin
            bit_count_nxt  = '0;
            phase_nxt      = PH_IDLE;
            res.frame_done = 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase

      if (next_line) begin
        bit_count_nxt = '0;
        if (cur_line_r >= last_line_r) begin
          go_trail = 1'b1;
        end else begin
          cur_line_nxt = cur_line_r + 1'b1;
          req.re       = 1'b1;
          req.addr     = cur_line_r + 1'b1;
          phase_nxt    = PH_ADDR;
        end
      end

      if (go_trail) begin
        bit_count_nxt = '0;
        if (TRAILER_CLOCKS == 0) begin
          phase_nxt      = PH_IDLE;
          res.frame_done = 1'b1;
        end else begin
          phase_nxt = PH_TRAIL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= '0;
      cur_line_r  <= '0;
      last_line_r <= '0;
      mode_word_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      cur_line_r  <= cur_line_nxt;
      last_line_r <= last_line_nxt;
      mode_word_r <= mode_word_nxt;
    end
  end

  assign running = (phase_r != PH_IDLE);

endmodule
